// ===== hdl/dimr_pkg.sv =====
// ----------------------------------------------------------------------------
// dimr_pkg
// Types, register indexes and field widths shared by the dimension-order
// mesh router blocks.
// ----------------------------------------------------------------------------
package dimr_pkg;

  // Fixed field widths
  localparam int HOP_W         = 16;
  localparam int NODE_FIELD_W  = 16;
  localparam int NUM_DIMS_W    = 3;
  localparam int DIM_SIZE_W    = 5;
  localparam int COORD_W       = 4;
  localparam int DIV_BITS      = 4;
  localparam int DIM_SIZE_CAP  = 16;

  // Configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 5;
  localparam int NUM_SIZE_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM0_SIZE = 3'd1;

  localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RST   = 3'd2;
  localparam logic [DIM_SIZE_W-1:0] DIM_SIZE_RST_LO = 5'd4;
  localparam logic [DIM_SIZE_W-1:0] DIM_SIZE_RST_HI = 5'd1;
  localparam int                    NUM_RST_LO_DIMS = 2;

  localparam int ROUTE_KIND_W = 2;

  typedef enum logic [ROUTE_KIND_W-1:0] {
    KIND_LINKED,
    KIND_NOSHAPE,
    KIND_MESH
  } route_kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_JOIN,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SRC,
    B_DST,
    B_WALK
  } back_state_e;

  // Width of one queued route job
  function automatic int entry_width(input int max_dims, input int id_bits);
    return ROUTE_KIND_W + 3 * id_bits + max_dims * (2 * COORD_W + id_bits);
  endfunction

endpackage

// ===== hdl/dimr_front.sv =====
// ----------------------------------------------------------------------------
// dimr_front
// Accepts route requests, classifies them and splits mesh ids into
// coordinates with an iterative divider, then builds strides and the joined
// start id before handing the job to the queue.
// ----------------------------------------------------------------------------
module dimr_front import dimr_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16,
  localparam int ND_W        = $clog2(MAX_DIMS + 1),
  localparam int ENTRY_W     = entry_width(MAX_DIMS, NODE_ID_BITS)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [NODE_FIELD_W-1:0]                src_node_i,
  input  logic [NODE_FIELD_W-1:0]                dest_node_i,
  input  logic                                   directly_linked_i,
  input  logic [ND_W-1:0]                        nd_i,
  input  logic [MAX_DIMS-1:0][DIM_SIZE_W-1:0]    size_i,
  output logic                                   push_valid_o,
  input  logic                                   push_stall_i,
  output logic [ENTRY_W-1:0]                     push_data_o
);

  localparam int NB    = NODE_ID_BITS;
  localparam int QW    = ((NB + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int NSTEP = QW / DIV_BITS;
  localparam int SC_W  = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  typedef struct packed {
    route_kind_e                          kind;
    logic [NB-1:0]                        src;
    logic [NB-1:0]                        dst;
    logic [NB-1:0]                        base;
    logic [MAX_DIMS-1:0][COORD_W-1:0]     cur;
    logic [MAX_DIMS-1:0][COORD_W-1:0]     tgt;
    logic [MAX_DIMS-1:0][NB-1:0]          stride;
  } entry_t;

  // Restoring division, DIV_BITS quotient bits per call
  function automatic logic [QW+COORD_W-1:0] div_step(
    input logic [QW-1:0]         q,
    input logic [COORD_W-1:0]    r,
    input logic [DIM_SIZE_W-1:0] s
  );
    logic [QW-1:0]      qq;
    logic [COORD_W:0]   t;
    logic [COORD_W-1:0] rr;
    qq = q;
    rr = r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {rr, qq[QW-1]};
      qq = {qq[QW-2:0], 1'b0};
      if (t >= s) begin
        t     = t - s;
        qq[0] = 1'b1;
      end
      rr = t[COORD_W-1:0];
    end
    return {qq, rr};
  endfunction

  front_state_e state_q, state_d;
  route_kind_e  kind_q;
  logic [NB-1:0] src_q, dst_q, base_q, stride_q;
  logic [QW-1:0] qs_q, qd_q;
  logic [COORD_W-1:0] rs_q, rd_q;
  logic [SC_W-1:0] step_q;
  logic [DIM_W-1:0] dim_q;
  logic [MAX_DIMS-1:0][COORD_W-1:0] cur_q, tgt_q;
  logic [MAX_DIMS-1:0][NB-1:0] strides_q;

  logic [QW+COORD_W-1:0] ds, dd;
  logic [DIM_SIZE_W-1:0] size_cur;
  logic dim_last, step_last, accept;
  logic [NB-1:0] src_m, dst_m;
  entry_t entry;

  assign src_m     = NB'(src_node_i);
  assign dst_m     = NB'(dest_node_i);
  assign size_cur  = size_i[dim_q];
  assign ds        = div_step(qs_q, rs_q, size_cur);
  assign dd        = div_step(qd_q, rd_q, size_cur);
  assign dim_last  = (ND_W'(dim_q) + ND_W'(1)) == nd_i;
  assign step_last = step_q == SC_W'(NSTEP - 1);
  assign accept    = (state_q == F_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = (directly_linked_i || nd_i == '0) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (step_last && dim_last) begin
          state_d = F_JOIN;
        end
      end
      F_JOIN: begin
        if (dim_last) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!push_stall_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != F_IDLE);
    push_valid_o = (state_q == F_PUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= src_m;
      dst_q  <= dst_m;
      qs_q   <= QW'(src_m);
      qd_q   <= QW'(dst_m);
      rs_q   <= '0;
      rd_q   <= '0;
      step_q <= '0;
      dim_q  <= '0;
      cur_q  <= '0;
      tgt_q  <= '0;
      base_q <= '0;
      if (directly_linked_i) begin
        kind_q <= KIND_LINKED;
      end else if (nd_i == '0) begin
        kind_q <= KIND_NOSHAPE;
      end else begin
        kind_q <= KIND_MESH;
      end
    end else if (state_q == F_DIV) begin
      qs_q <= ds[QW+COORD_W-1:COORD_W];
      qd_q <= dd[QW+COORD_W-1:COORD_W];
      if (step_last) begin
        // remainder is this dimension's coordinate, quotient feeds the next
        cur_q[dim_q] <= ds[COORD_W-1:0];
        tgt_q[dim_q] <= dd[COORD_W-1:0];
        rs_q         <= '0;
        rd_q         <= '0;
        step_q       <= '0;
        if (dim_last) begin
          dim_q    <= '0;
          base_q   <= '0;
          stride_q <= NB'(1);
        end else begin
          dim_q <= dim_q + DIM_W'(1);
        end
      end else begin
        rs_q   <= ds[COORD_W-1:0];
        rd_q   <= dd[COORD_W-1:0];
        step_q <= step_q + SC_W'(1);
      end
    end else if (state_q == F_JOIN) begin
      base_q           <= base_q + stride_q * NB'(cur_q[dim_q]);
      strides_q[dim_q] <= stride_q;
      stride_q         <= stride_q * NB'(size_i[dim_q]);
      dim_q            <= dim_q + DIM_W'(1);
    end
  end

  always_comb begin
    entry.kind   = kind_q;
    entry.src    = src_q;
    entry.dst    = dst_q;
    entry.base   = base_q;
    entry.cur    = cur_q;
    entry.tgt    = tgt_q;
    entry.stride = strides_q;
    push_data_o  = entry;
  end

endmodule

// ===== hdl/dimr_queue.sv =====
// ----------------------------------------------------------------------------
// dimr_queue
// Small register queue that decouples route setup from hop emission.
// ----------------------------------------------------------------------------
module dimr_queue import dimr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic push, pop;

  assign push_stall_o = (count_q == CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/dimr_back.sv =====
// ----------------------------------------------------------------------------
// dimr_back
// Walks one queued route job and emits its hops, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module dimr_back import dimr_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16,
  localparam int ENTRY_W     = entry_width(MAX_DIMS, NODE_ID_BITS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_stall_o,
  input  logic [ENTRY_W-1:0] pop_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [HOP_W-1:0]   hop_node_o,
  output logic               last_hop_o
);

  localparam int NB    = NODE_ID_BITS;
  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  typedef struct packed {
    route_kind_e                          kind;
    logic [NB-1:0]                        src;
    logic [NB-1:0]                        dst;
    logic [NB-1:0]                        base;
    logic [MAX_DIMS-1:0][COORD_W-1:0]     cur;
    logic [MAX_DIMS-1:0][COORD_W-1:0]     tgt;
    logic [MAX_DIMS-1:0][NB-1:0]          stride;
  } entry_t;

  back_state_e state_q, state_d;
  route_kind_e kind_q;
  logic [NB-1:0] src_q, dst_q, id_q;
  logic [MAX_DIMS-1:0][COORD_W-1:0] cur_q, tgt_q;
  logic [MAX_DIMS-1:0][NB-1:0] strides_q;
  logic out_valid_q, last_q;
  logic [HOP_W-1:0] hop_q;

  entry_t entry;
  logic [MAX_DIMS-1:0] neq, neq_next;
  logic [MAX_DIMS-1:0][COORD_W-1:0] cur_next;
  logic [DIM_W-1:0] k;
  logic up, out_free, emit, emit_last;
  logic [NB-1:0] id_next, emit_hop;

  assign entry    = pop_data_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Step the highest dimension that still differs
  always_comb begin
    k = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      neq[d] = (cur_q[d] != tgt_q[d]);
      if (neq[d]) begin
        k = DIM_W'(d);
      end
    end
    up       = cur_q[k] < tgt_q[k];
    cur_next = cur_q;
    cur_next[k] = up ? cur_q[k] + COORD_W'(1) : cur_q[k] - COORD_W'(1);
    id_next  = up ? id_q + strides_q[k] : id_q - strides_q[k];
    neq_next = neq;
    neq_next[k] = (cur_next[k] != tgt_q[k]);
  end

  always_comb begin
    emit      = 1'b0;
    emit_hop  = src_q;
    emit_last = 1'b0;
    case (state_q)
      B_SRC: begin
        emit = out_free;
        case (kind_q)
          KIND_LINKED:  emit_last = (src_q == dst_q);
          KIND_NOSHAPE: emit_last = 1'b0;
          default:      emit_last = (neq == '0);
        endcase
      end
      B_DST: begin
        emit      = out_free;
        emit_hop  = dst_q;
        emit_last = 1'b1;
      end
      B_WALK: begin
        emit      = out_free;
        emit_hop  = id_next;
        emit_last = (neq_next == '0);
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = B_SRC;
        end
      end
      B_SRC: begin
        if (emit) begin
          if (emit_last) begin
            state_d = B_IDLE;
          end else begin
            state_d = (kind_q == KIND_MESH) ? B_WALK : B_DST;
          end
        end
      end
      B_DST: begin
        if (emit) begin
          state_d = B_IDLE;
        end
      end
      B_WALK: begin
        if (emit && emit_last) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign pop_stall_o = (state_q != B_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_valid_i) begin
      kind_q    <= entry.kind;
      src_q     <= entry.src;
      dst_q     <= entry.dst;
      id_q      <= entry.base;
      cur_q     <= entry.cur;
      tgt_q     <= entry.tgt;
      strides_q <= entry.stride;
    end else if (state_q == B_WALK && emit) begin
      cur_q <= cur_next;
      id_q  <= id_next;
    end
    if (emit) begin
      hop_q  <= HOP_W'(emit_hop);
      last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hop_node_o  = hop_q;
  assign last_hop_o  = last_q;

endmodule

// ===== hdl/dimension_order_mesh_router_unit.sv =====
// ----------------------------------------------------------------------------
// dimension_order_mesh_router_unit
// Dimension-order path generator for a mixed-radix mesh of up to MAX_DIMS
// dimensions.
// ----------------------------------------------------------------------------
// A request (source id, destination id, direct-link flag) produces its path
// as a stream of hop node ids, the last one flagged with last_hop_o. The
// first hop is always the raw source id. Mesh requests are set up by the
// front section: an iterative coordinate divider for each configured
// dimension (4 quotient bits per cycle), then a pass over the dimensions
// to build strides and the start id, then a push of the job into the
// queue; direct-link and no-shape requests skip that setup. The back
// section loads a job and then emits one hop per cycle while the output
// is not stalled. A two-entry job queue lets setup of the next request
// overlap emission of the current one. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i and must only change
// while the unit is idle.
// ----------------------------------------------------------------------------
module dimension_order_mesh_router_unit import dimr_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NODE_FIELD_W-1:0] src_node_i,
  input  logic [NODE_FIELD_W-1:0] dest_node_i,
  input  logic                    directly_linked_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [HOP_W-1:0]        hop_node_o,
  output logic                    last_hop_o
);

  localparam int ND_W    = $clog2(MAX_DIMS + 1);
  localparam int ENTRY_W = entry_width(MAX_DIMS, NODE_ID_BITS);

  logic [NUM_DIMS_W-1:0]               num_dims_q;
  logic [MAX_DIMS-1:0][DIM_SIZE_W-1:0] dim_size_q;
  logic [MAX_DIMS-1:0][DIM_SIZE_W-1:0] size_eff;
  logic [ND_W-1:0]                     nd_eff;

  logic               q_push_valid, q_push_stall;
  logic               q_pop_valid, q_pop_stall;
  logic [ENTRY_W-1:0] q_push_data, q_pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= NUM_DIMS_RST;
    end else if (cfg_we_i && cfg_idx_i == REG_NUM_DIMS) begin
      num_dims_q <= cfg_data_i[NUM_DIMS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        dim_size_q[d] <= (d < NUM_RST_LO_DIMS) ? DIM_SIZE_RST_LO : DIM_SIZE_RST_HI;
      end
    end else if (cfg_we_i) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (d < NUM_SIZE_REGS &&
            cfg_idx_i == CFG_IDX_W'(int'(REG_DIM0_SIZE) + d)) begin
          dim_size_q[d] <= cfg_data_i;
        end
      end
    end
  end

  // Zero counts as one node, anything above the cap as the cap
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (dim_size_q[d] == '0) begin
        size_eff[d] = DIM_SIZE_W'(1);
      end else if (dim_size_q[d] > DIM_SIZE_W'(DIM_SIZE_CAP)) begin
        size_eff[d] = DIM_SIZE_W'(DIM_SIZE_CAP);
      end else begin
        size_eff[d] = dim_size_q[d];
      end
    end
  end

  always_comb begin
    if ({1'b0, num_dims_q} > 4'(MAX_DIMS)) begin
      nd_eff = ND_W'(MAX_DIMS);
    end else begin
      nd_eff = ND_W'(num_dims_q);
    end
  end

  dimr_front #(
    .MAX_DIMS    (MAX_DIMS),
    .NODE_ID_BITS(NODE_ID_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .src_node_i       (src_node_i),
    .dest_node_i      (dest_node_i),
    .directly_linked_i(directly_linked_i),
    .nd_i             (nd_eff),
    .size_i           (size_eff),
    .push_valid_o     (q_push_valid),
    .push_stall_i     (q_push_stall),
    .push_data_o      (q_push_data)
  );

  dimr_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_stall_o(q_push_stall),
    .push_data_i (q_push_data),
    .pop_valid_o (q_pop_valid),
    .pop_stall_i (q_pop_stall),
    .pop_data_o  (q_pop_data)
  );

  dimr_back #(
    .MAX_DIMS    (MAX_DIMS),
    .NODE_ID_BITS(NODE_ID_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(q_pop_valid),
    .pop_stall_o(q_pop_stall),
    .pop_data_i (q_pop_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hop_node_o (hop_node_o),
    .last_hop_o (last_hop_o)
  );

  // Front holds off new requests while it works on an accepted one
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front accepted back-to-back requests");

  // Back walks one job at a time
  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && !q_pop_stall |=> q_pop_stall)
    else $error("back did not start on popped job");

  // A pending non-final hop means the path is still being walked
  a_hop_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_hop_o |-> q_pop_stall)
    else $error("back went idle before the final hop");

endmodule

// ===== tb/sv/dimr_route_checker.sv =====
// ----------------------------------------------------------------------------
// dimr_route_checker
// Watches the request, result and register ports of the mesh router, works
// out the hop sequence for every accepted request and compares each result
// transfer against the oldest hop still due.
// ----------------------------------------------------------------------------
module dimr_route_checker import dimr_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [NODE_FIELD_W-1:0] src_node_i,
  input  logic [NODE_FIELD_W-1:0] dest_node_i,
  input  logic                    directly_linked_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [HOP_W-1:0]        hop_node_i,
  input  logic                    last_hop_i,
  output int                      fail_count_o,
  output int                      hops_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [HOP_W-1:0] node;
    logic             last;
  } hop_t;

  hop_t                  hops_due[$];
  logic [NUM_DIMS_W-1:0] dims_cfg;
  logic [DIM_SIZE_W-1:0] size_cfg [MAX_DIMS];
  int                    fails = 0;

  initial begin
    fail_count_o   = 0;
    hops_pending_o = 0;
  end

  // Zero counts as one node, anything past the cap is clipped.
  function automatic int dim_span(input int d);
    if (size_cfg[d] == '0) return 1;
    if (size_cfg[d] > DIM_SIZE_CAP) return DIM_SIZE_CAP;
    return int'(size_cfg[d]);
  endfunction

  function automatic logic [HOP_W-1:0] id_bits(input longint unsigned id);
    longint unsigned keep;
    keep = (64'd1 << NODE_ID_BITS) - 1;
    return HOP_W'(id & keep);
  endfunction

  function automatic void add_hop(input logic [HOP_W-1:0] node);
    hop_t h;
    h.node = node;
    h.last = 1'b0;
    hops_due.insert(hops_due.size(), h);
  endfunction

  function automatic void plan_route(input logic [NODE_FIELD_W-1:0] src,
                                     input logic [NODE_FIELD_W-1:0] dst,
                                     input logic                    linked);
    int              nd;
    int              here [MAX_DIMS];
    int              goal [MAX_DIMS];
    longint unsigned s;
    longint unsigned t;
    longint unsigned stride;
    longint unsigned id;
    s  = id_bits(src);
    t  = id_bits(dst);
    nd = (dims_cfg > MAX_DIMS) ? MAX_DIMS : int'(dims_cfg);
    // The raw source always leads the path.
    add_hop(HOP_W'(s));
    if (linked) begin
      if (s != t) add_hop(HOP_W'(t));
    end else if (nd == 0) begin
      add_hop(HOP_W'(t));
    end else begin
      stride = 1;
      for (int k = 0; k < nd; k++) begin
        here[k] = int'((s / stride) % dim_span(k));
        goal[k] = int'((t / stride) % dim_span(k));
        stride  = stride * dim_span(k);
      end
      // Walk the highest dimension first, one step per hop.
      for (int k = nd - 1; k >= 0; k--) begin
        while (here[k] != goal[k]) begin
          here[k] += (here[k] < goal[k]) ? 1 : -1;
          id     = 0;
          stride = 1;
          for (int j = 0; j < nd; j++) begin
            id     += longint'(here[j]) * stride;
            stride  = stride * dim_span(j);
          end
          add_hop(id_bits(id));
        end
      end
    end
    hops_due[hops_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hop_t want;
    if (!rst_ni) begin
      dims_cfg = NUM_DIMS_RST;
      for (int d = 0; d < MAX_DIMS; d++) begin
        size_cfg[d] = (d < NUM_RST_LO_DIMS) ? DIM_SIZE_RST_LO : DIM_SIZE_RST_HI;
      end
      hops_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NUM_DIMS) begin
          dims_cfg = cfg_data_i[NUM_DIMS_W-1:0];
        end else if (cfg_idx_i >= REG_DIM0_SIZE &&
                     int'(cfg_idx_i) < int'(REG_DIM0_SIZE) + NUM_SIZE_REGS &&
                     int'(cfg_idx_i - REG_DIM0_SIZE) < MAX_DIMS) begin
          size_cfg[cfg_idx_i - REG_DIM0_SIZE] = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        plan_route(src_node_i, dest_node_i, directly_linked_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (hops_due.size() == 0) begin
          $error("hop_node: no hop due, got %0h (last_hop %0b)", hop_node_i, last_hop_i);
          fails++;
        end else begin
          want = hops_due.pop_front();
          if (hop_node_i !== want.node) begin
            $error("hop_node: expected %0h, got %0h", want.node, hop_node_i);
            fails++;
          end
          if (last_hop_i !== want.last) begin
            $error("last_hop: expected %0b, got %0b", want.last, last_hop_i);
            fails++;
          end
        end
      end
    end
    hops_pending_o = hops_due.size();
    fail_count_o   = fails;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives route requests and register writes into the mesh router under
// random idle and stall bursts: a directed pass over the corner cases, then
// random traffic over several mesh shapes. The checker does the comparison.
// ----------------------------------------------------------------------------
module testbench import dimr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [NODE_FIELD_W-1:0] src_node_i;
  logic [NODE_FIELD_W-1:0] dest_node_i;
  logic                    directly_linked_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [HOP_W-1:0]        hop_node_o;
  logic                    last_hop_o;

  int fail_count;
  int hops_pending;
  bit idle_on;
  int mesh_dims;
  int mesh_nodes;

  dimension_order_mesh_router_unit #(
    .MAX_DIMS     (4),
    .NODE_ID_BITS (16)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .src_node_i        (src_node_i),
    .dest_node_i       (dest_node_i),
    .directly_linked_i (directly_linked_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hop_node_o        (hop_node_o),
    .last_hop_o        (last_hop_o)
  );

  dimr_route_checker #(
    .MAX_DIMS     (4),
    .NODE_ID_BITS (16)
  ) route_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .src_node_i        (src_node_i),
    .dest_node_i       (dest_node_i),
    .directly_linked_i (directly_linked_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hop_node_i        (hop_node_o),
    .last_hop_i        (last_hop_o),
    .fail_count_o      (fail_count),
    .hops_pending_o    (hops_pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && rst_ni && $urandom_range(0, 9) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic route(input logic [NODE_FIELD_W-1:0] src,
                       input logic [NODE_FIELD_W-1:0] dst,
                       input logic                    linked);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    src_node_i        = src;
    dest_node_i       = dst;
    directly_linked_i = linked;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold off until every hop due has come out.
  task automatic drain();
    in_valid_i = 1'b0;
    while (hops_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_mesh(input logic [CFG_DATA_W-1:0] dims,
                          input logic [CFG_DATA_W-1:0] s0,
                          input logic [CFG_DATA_W-1:0] s1,
                          input logic [CFG_DATA_W-1:0] s2,
                          input logic [CFG_DATA_W-1:0] s3);
    logic [CFG_DATA_W-1:0] sz [4];
    int                    span;
    sz = '{s0, s1, s2, s3};
    drain();
    write_reg(REG_NUM_DIMS, dims);
    for (int d = 0; d < NUM_SIZE_REGS; d++) begin
      write_reg(REG_DIM0_SIZE + CFG_IDX_W'(d), sz[d]);
    end
    mesh_dims  = (dims[NUM_DIMS_W-1:0] > 4) ? 4 : int'(dims[NUM_DIMS_W-1:0]);
    mesh_nodes = 1;
    for (int d = 0; d < mesh_dims; d++) begin
      span = (sz[d] == '0) ? 1 : (sz[d] > DIM_SIZE_CAP) ? DIM_SIZE_CAP : int'(sz[d]);
      mesh_nodes *= span;
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    if ($urandom_range(0, 3) != 0) return CFG_DATA_W'($urandom_range(1, 8));
    return CFG_DATA_W'($urandom_range(0, 31));
  endfunction

  // Mostly ids inside the mesh, some full-width noise.
  function automatic logic [NODE_FIELD_W-1:0] pick_node();
    if (mesh_dims == 0 || $urandom_range(0, 7) == 0) return NODE_FIELD_W'($urandom);
    return NODE_FIELD_W'($urandom_range(0, mesh_nodes - 1));
  endfunction

  task automatic random_route();
    logic [NODE_FIELD_W-1:0] src;
    logic [NODE_FIELD_W-1:0] dst;
    src = pick_node();
    dst = ($urandom_range(0, 15) == 0) ? src : pick_node();
    route(src, dst, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_NUM_DIMS;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    src_node_i        = '0;
    dest_node_i       = '0;
    directly_linked_i = 1'b0;
    idle_on           = 1'b1;
    mesh_dims         = 2;
    mesh_nodes        = 16;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset shape: 4x4 mesh.
    route(16'h0000, 16'h000F, 1'b0);
    route(16'h000F, 16'h0000, 1'b0);
    route(16'h0005, 16'h0005, 1'b0);
    route(16'h0003, 16'h0003, 1'b1);
    route(16'hFFFF, 16'h0000, 1'b1);
    route(16'h0000, 16'hFFFF, 1'b0);
    route(16'h0010, 16'h0000, 1'b0);

    // No shape: source then destination, even when equal.
    set_mesh(5'd0, 5'd4, 5'd4, 5'd1, 5'd1);
    route(16'h0007, 16'h0007, 1'b0);
    route(16'hFFFF, 16'h0000, 1'b0);
    route(16'h0001, 16'h0002, 1'b1);

    // Dimension count past the limit, largest mesh, longest paths.
    set_mesh(5'd7, 5'd16, 5'd16, 5'd16, 5'd16);
    route(16'h0000, 16'hFFFF, 1'b0);
    route(16'hFFFF, 16'h0000, 1'b0);
    route(16'h1234, 16'hFEDC, 1'b0);

    // Zero size counts as one, oversized sizes clip.
    set_mesh(5'd4, 5'd0, 5'd31, 5'd17, 5'd1);
    route(16'h0000, 16'h00FF, 1'b0);
    route(16'hABCD, 16'h0123, 1'b0);

    // Writes to unused indexes must leave the shape alone.
    drain();
    write_reg(REG_DIM0_SIZE + CFG_IDX_W'(NUM_SIZE_REGS), 5'd3);
    write_reg(REG_DIM0_SIZE + CFG_IDX_W'(NUM_SIZE_REGS + 1), 5'd2);
    write_reg(REG_DIM0_SIZE + CFG_IDX_W'(NUM_SIZE_REGS + 2), 5'd31);
    route(16'h0000, 16'hFFFF, 1'b0);

    set_mesh(5'd1, 5'd16, 5'd1, 5'd1, 5'd1);
    route(16'h0000, 16'h000F, 1'b0);
    route(16'hFFF0, 16'h000F, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_mesh(5'd4, 5'd16, 5'd16, 5'd16, 5'd16);
        1: set_mesh(5'd0, pick_size(), pick_size(), pick_size(), pick_size());
        2: set_mesh(5'd4, 5'd1, 5'd1, 5'd1, 5'd1);
        default: begin
          set_mesh({2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))},
                   pick_size(), pick_size(), pick_size(), pick_size());
        end
      endcase
      idle_on = (phase % 3 != 2) && (phase != 7);
      repeat (44) random_route();
    end

    drain();
    repeat (64) @(negedge clk_i);
    if (fail_count == 0 && hops_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (hops_pending != 0) $error("hop_node: %0d hops never came out", hops_pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dimr_pkg.sv
hdl/dimr_front.sv
hdl/dimr_queue.sv
hdl/dimr_back.sv
hdl/dimension_order_mesh_router_unit.sv
tb/sv/dimr_route_checker.sv
tb/sv/testbench.sv
